// ===== hw/rtl/aging_priority_scheduler_unit_defines.svh =====
// Assertion macros shared by the aging priority scheduler RTL.
// Used by files that take it in with an include; needs clk and arst_n in scope.
`ifndef AGING_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define AGING_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define APS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define APS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/aps_pkg.sv =====
// Package for the aging priority scheduler: codes, field widths and the
// command/status structs between controller and datapath. No dependencies.
package aps_pkg;

	localparam int ID_W   = 16;
	localparam int SEV_W  = 2;
	localparam int TIME_W = 16;
	localparam int OP_W   = 2;
	localparam int STAT_W = 3;
	localparam int SRV_OUT_W = 2;
	localparam int CNT_OUT_W = 5;

	typedef logic [STAT_W-1:0] status_t;
	typedef logic [OP_W-1:0]   op_t;

	// Operation codes
	localparam op_t OP_ADD    = 2'd0;
	localparam op_t OP_TREAT  = 2'd1;
	localparam op_t OP_SEARCH = 2'd2;

	// Status codes
	localparam status_t ST_DONE   = 3'd0;
	localparam status_t ST_EMPTY  = 3'd1;
	localparam status_t ST_FULL   = 3'd2;
	localparam status_t ST_MISS   = 3'd3;
	localparam status_t ST_BADSEV = 3'd4;

	// One queue entry as held in the entry RAM
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [SEV_W-1:0]  sev;
		logic [TIME_W-1:0] arrival;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic    load;          // latch the accepted word
		logic    scan_clr;      // reset slot index and best-so-far
		logic    free_step;     // advance slot index during free-slot search
		logic    scan_rd;       // read entry at slot index, then advance
		logic    add_commit;
		logic    treat_commit;
		logic    search_commit;
		logic    flag_commit;   // finish with flag_status, no state change
		status_t flag_status;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic sev_zero;
		logic full;
		logic empty;
		logic slot_free;
		logic idx_last;
	} dp_stat_t;

endpackage

// ===== hw/rtl/aps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/aps_ctrl.sv =====
// Controller FSM of the aging priority scheduler: sequences decode,
// free-slot search, slot scan and commit. Depends on aps_pkg.
`include "aging_priority_scheduler_unit_defines.svh"

module aps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  aps_pkg::dp_stat_t stat,
	output aps_pkg::dp_cmd_t  cmd
);

	import aps_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_FREE   = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_TAIL   = 3'd4;
	localparam logic [2:0] S_COMMIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.flag_status = ST_DONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.op == OP_ADD) begin
					if (stat.sev_zero) begin
						cmd.flag_commit = 1'b1;
						cmd.flag_status = ST_BADSEV;
						state_d = S_IDLE;
					end else if (stat.full) begin
						cmd.flag_commit = 1'b1;
						cmd.flag_status = ST_FULL;
						state_d = S_IDLE;
					end else begin
						cmd.scan_clr = 1'b1;
						state_d = S_FREE;
					end
				end else if (stat.op == OP_TREAT) begin
					if (stat.empty) begin
						cmd.flag_commit = 1'b1;
						cmd.flag_status = ST_EMPTY;
						state_d = S_IDLE;
					end else begin
						cmd.scan_clr = 1'b1;
						state_d = S_SCAN;
					end
				end else if (stat.op == OP_SEARCH) begin
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end else begin
					// unused operation: report done, touch nothing
					cmd.flag_commit = 1'b1;
					cmd.flag_status = ST_DONE;
					state_d = S_IDLE;
				end
			end
			S_FREE: begin
				if (stat.slot_free) begin
					cmd.add_commit = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.free_step = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.idx_last) begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				// last read is compared in this cycle
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (stat.op == OP_TREAT) begin
					cmd.treat_commit = 1'b1;
				end else begin
					cmd.search_commit = 1'b1;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`APS_ASSERT_NEXT(a_accept_decides, start && !busy, state_q == S_DECIDE, "accepted word did not reach decode")

endmodule

// ===== hw/rtl/aps_dpath.sv =====
// Datapath of the aging priority scheduler: valid bits, entry RAM, counters,
// best-slot tracking and result registers. Depends on aps_pkg and aps_ram.
`include "aging_priority_scheduler_unit_defines.svh"

module aps_dpath #(
	parameter int QUEUE_DEPTH    = 16,
	parameter int SERVERS        = 4,
	parameter int AGING_INTERVAL = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  aps_pkg::dp_cmd_t                   cmd,
	output aps_pkg::dp_stat_t                  stat,
	input  logic [aps_pkg::OP_W-1:0]           operation,
	input  logic [aps_pkg::SEV_W-1:0]          severity,
	input  logic [aps_pkg::ID_W-1:0]           query_id,
	output logic                               done,
	output aps_pkg::status_t                   status,
	output logic [aps_pkg::ID_W-1:0]           request_id,
	output logic [aps_pkg::SEV_W-1:0]          request_severity,
	output logic [aps_pkg::SRV_OUT_W-1:0]      server,
	output logic [aps_pkg::ID_W-1:0]           last_served_id,
	output logic [aps_pkg::CNT_OUT_W-1:0]      queue_count
);

	import aps_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SRV_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;
	localparam logic [TIME_W:0] AGE1 = (TIME_W+1)'(AGING_INTERVAL);
	localparam logic [TIME_W:0] AGE2 = (TIME_W+1)'(2 * AGING_INTERVAL);

	// effective priority: severity less aging steps, floor 1
	function automatic logic [SEV_W-1:0] eff_prio(input logic [SEV_W-1:0] sev,
			input logic [TIME_W-1:0] wt);
		logic [TIME_W:0]  w;
		logic [SEV_W-1:0] e;
		begin
			w = {1'b0, wt};
			e = 2'd1;
			case (sev)
				2'd2: begin
					e = (w >= AGE1) ? 2'd1 : 2'd2;
				end
				2'd3: begin
					if (w >= AGE2) begin
						e = 2'd1;
					end else if (w >= AGE1) begin
						e = 2'd2;
					end else begin
						e = 2'd3;
					end
				end
				default: begin
					e = 2'd1;
				end
			endcase
			return e;
		end
	endfunction

	// control state
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]       count_q;
	logic [TIME_W-1:0]      time_q;
	logic [ID_W-1:0]        next_id_q;
	logic [SRV_W-1:0]       srv_ptr_q;
	logic [ID_W-1:0]        last_served_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   rd_s1;
	logic                   best_found_q;
	logic                   done_q;

	// latched word and scan payload
	op_t               op_q;
	logic [SEV_W-1:0]  sev_q;
	logic [ID_W-1:0]   qid_q;
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  best_slot_q;
	logic [ID_W-1:0]   best_id_q;
	logic [SEV_W-1:0]  best_sev_q;
	logic [SEV_W-1:0]  best_eff_q;
	logic [TIME_W-1:0] best_wait_q;

	// result registers
	status_t           status_q;
	logic [ID_W-1:0]   rid_q;
	logic [SEV_W-1:0]  rsev_q;
	logic [SRV_OUT_W-1:0] srv_q;

	// entry RAM
	entry_t            wr_ent;
	logic [$bits(entry_t)-1:0] rd_word;
	entry_t            rd_ent;

	assign wr_ent = '{id: next_id_q, sev: sev_q, arrival: time_q};
	assign rd_ent = entry_t'(rd_word);

	aps_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (cmd.add_commit),
		.wr_addr (idx_q),
		.wr_data (wr_ent),
		.rd_en   (cmd.scan_rd),
		.rd_addr (idx_q),
		.rd_data (rd_word)
	);

	// compare of the slot read in the previous cycle against the best so far
	logic [TIME_W-1:0] cand_wait;
	logic [SEV_W-1:0]  cand_eff;
	logic              cand_ok;
	logic              cand_better;

	always_comb begin
		cand_wait = time_q - rd_ent.arrival;
		cand_eff  = eff_prio(rd_ent.sev, cand_wait);
		cand_ok   = rd_s1 && valid_q[idx_s1] &&
		            ((op_q == OP_TREAT) || (rd_ent.id == qid_q));
		cand_better = !best_found_q || (cand_eff < best_eff_q) ||
		              ((cand_eff == best_eff_q) && (cand_wait > best_wait_q));
	end

	// status to controller
	assign stat.op        = op_q;
	assign stat.sev_zero  = (sev_q == '0);
	assign stat.full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty     = (count_q == '0);
	assign stat.slot_free = !valid_q[idx_q];
	assign stat.idx_last  = (idx_q == IDX_W'(QUEUE_DEPTH - 1));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			count_q       <= '0;
			time_q        <= '0;
			next_id_q     <= ID_W'(1);
			srv_ptr_q     <= '0;
			last_served_q <= '0;
			idx_q         <= '0;
			rd_s1         <= 1'b0;
			best_found_q  <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			rd_s1  <= cmd.scan_rd;
			done_q <= cmd.flag_commit | cmd.add_commit | cmd.treat_commit |
			          cmd.search_commit;
			if (cmd.scan_clr) begin
				idx_q <= '0;
			end else if (cmd.free_step || cmd.scan_rd) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.scan_clr) begin
				best_found_q <= 1'b0;
			end else if (cand_ok) begin
				best_found_q <= 1'b1;
			end
			if (cmd.add_commit) begin
				valid_q[idx_q] <= 1'b1;
				count_q   <= count_q + 1'b1;
				next_id_q <= next_id_q + 1'b1;
				time_q    <= time_q + 1'b1;
			end
			if (cmd.treat_commit) begin
				valid_q[best_slot_q] <= 1'b0;
				count_q       <= count_q - 1'b1;
				last_served_q <= best_id_q;
				if (srv_ptr_q == SRV_W'(SERVERS - 1)) begin
					srv_ptr_q <= '0;
				end else begin
					srv_ptr_q <= srv_ptr_q + 1'b1;
				end
			end
		end
	end

	// payload registers: latched word, read pipeline, best-so-far
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			sev_q <= severity;
			qid_q <= query_id;
		end
		if (cmd.scan_rd) begin
			idx_s1 <= idx_q;
		end
		if (cand_ok && cand_better) begin
			best_slot_q <= idx_s1;
			best_id_q   <= rd_ent.id;
			best_sev_q  <= rd_ent.sev;
			best_eff_q  <= cand_eff;
			best_wait_q <= cand_wait;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.flag_commit) begin
			status_q <= cmd.flag_status;
			rid_q    <= '0;
			rsev_q   <= '0;
			srv_q    <= '0;
		end else if (cmd.add_commit) begin
			status_q <= ST_DONE;
			rid_q    <= next_id_q;
			rsev_q   <= sev_q;
			srv_q    <= '0;
		end else if (cmd.treat_commit) begin
			status_q <= ST_DONE;
			rid_q    <= best_id_q;
			rsev_q   <= best_sev_q;
			srv_q    <= SRV_OUT_W'(srv_ptr_q);
		end else if (cmd.search_commit) begin
			status_q <= best_found_q ? ST_DONE : ST_MISS;
			rid_q    <= best_found_q ? best_id_q : '0;
			rsev_q   <= best_found_q ? best_sev_q : '0;
			srv_q    <= '0;
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign request_id       = rid_q;
	assign request_severity = rsev_q;
	assign server           = srv_q;
	assign last_served_id   = last_served_q;
	assign queue_count      = CNT_OUT_W'(count_q);

	`APS_ASSERT_NOW(a_count_tracks_valid, 1'b1, $countones(valid_q) == count_q, "fill count disagrees with valid bits")
	`APS_ASSERT_NOW(a_treat_has_best, cmd.treat_commit, best_found_q && valid_q[best_slot_q], "treat commit without a queued best entry")
	`APS_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe held beyond one cycle")

endmodule

// ===== hw/rtl/aging_priority_scheduler_unit.sv =====
// Aging priority scheduler. Flagged items, unused operations: decode, registered strobe.
// Add: decode, free-slot search with one slot checked per cycle, commit, registered strobe.
// Treat and search: decode, one entry RAM read per slot, tail compare, commit, strobe.
// busy falls in the strobe cycle, so a new word may start there. Results are not stalled.
// Asynchronous reset empties the queue: time 0, next id 1, server 0, last served 0.
// Top level: joins aps_ctrl and aps_dpath; depends on aps_pkg.
module aging_priority_scheduler_unit #(
	parameter int QUEUE_DEPTH    = 16,
	parameter int SERVERS        = 4,
	parameter int AGING_INTERVAL = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [aps_pkg::OP_W-1:0]      operation,
	input  logic [aps_pkg::SEV_W-1:0]     severity,
	input  logic [aps_pkg::ID_W-1:0]      query_id,
	output logic                          done,
	output aps_pkg::status_t              status,
	output logic [aps_pkg::ID_W-1:0]      request_id,
	output logic [aps_pkg::SEV_W-1:0]     request_severity,
	output logic [aps_pkg::SRV_OUT_W-1:0] server,
	output logic [aps_pkg::ID_W-1:0]      last_served_id,
	output logic [aps_pkg::CNT_OUT_W-1:0] queue_count
);

	import aps_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing
	aps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// storage, compare and results
	aps_dpath #(
		.QUEUE_DEPTH    (QUEUE_DEPTH),
		.SERVERS        (SERVERS),
		.AGING_INTERVAL (AGING_INTERVAL)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.operation        (operation),
		.severity         (severity),
		.query_id         (query_id),
		.done             (done),
		.status           (status),
		.request_id       (request_id),
		.request_severity (request_severity),
		.server           (server),
		.last_served_id   (last_served_id),
		.queue_count      (queue_count)
	);

endmodule
